// ===== rtl/cascaded_p_loop_with_kinematic_plant_core_assert.svh =====
// assertion macros for the cascaded p loop core
`ifndef CASCADED_P_LOOP_WITH_KINEMATIC_PLANT_CORE_ASSERT_SVH
`define CASCADED_P_LOOP_WITH_KINEMATIC_PLANT_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, off while rst_n is low
`define CPLP_ASSERT_IMPLY(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("cplp check failed");
// next-cycle implication
`define CPLP_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("cplp check failed");
`else
`define CPLP_ASSERT_IMPLY(label, lhs, rhs)
`define CPLP_ASSERT_NEXT(label, lhs, rhs)
`endif
`endif

// ===== rtl/cplp_pkg.sv =====
// shared types and constants for the cascaded p loop core
package cplp_pkg;

  localparam int CFG_W  = 32;
  localparam int STEP_W = 25;
  localparam int OUT_W  = 32;
  localparam int IDX_W  = 2;
  localparam int DIG_W  = 16;

  localparam logic [IDX_W-1:0] REG_TARGET_POSITION = 2'd0;
  localparam logic [IDX_W-1:0] REG_GUIDANCE_GAIN   = 2'd1;
  localparam logic [IDX_W-1:0] REG_CONTROL_GAIN    = 2'd2;

  localparam logic signed [CFG_W-1:0] TARGET_RESET = 32'sd0;
  localparam logic signed [CFG_W-1:0] GAIN_RESET   = 32'sd65536;

  typedef struct packed {
    logic signed [STEP_W-1:0] time_step;
  } in_payload_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] position_out;
    logic signed [OUT_W-1:0] velocity_out;
    logic signed [OUT_W-1:0] control_accel;
    logic                    step_error;
    logic                    saturated;
  } out_payload_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] value;
  } cfg_payload_t;

  typedef enum logic [2:0] {
    OP_VD  = 3'd0,
    OP_ACC = 3'd1,
    OP_DV  = 3'd2,
    OP_PV  = 3'd3,
    OP_HT  = 3'd4
  } op_t;

  typedef struct packed {
    logic take_in;
    logic mul_load;
    logic mul_step;
    logic mul_fin;
    logic update;
    logic put_out;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mul_last;
    logic step_err;
    logic out_full;
  } sts_t;

endpackage

// ===== rtl/cplp_stream_if.sv =====
// valid/ready channel carrying one request payload
interface cplp_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cplp_ctrl.sv =====
// sequencer stepping the shared multiplier through the five products
module cplp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cplp_pkg::sts_t sts,
  output cplp_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_FIN  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  cplp_pkg::op_t   op_r, op_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          op_nxt      = cplp_pkg::OP_VD;
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.mul_load = 1'b1;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.mul_fin = 1'b1;
        case (op_r)
          cplp_pkg::OP_VD: begin
            op_nxt    = cplp_pkg::OP_ACC;
            state_nxt = ST_LOAD;
          end
          cplp_pkg::OP_ACC: begin
            // negative step: no motion, report right away
            if (sts.step_err) begin
              state_nxt = ST_DONE;
            end else begin
              op_nxt    = cplp_pkg::OP_DV;
              state_nxt = ST_LOAD;
            end
          end
          cplp_pkg::OP_DV: begin
            op_nxt    = cplp_pkg::OP_PV;
            state_nxt = ST_LOAD;
          end
          cplp_pkg::OP_PV: begin
            op_nxt    = cplp_pkg::OP_HT;
            state_nxt = ST_LOAD;
          end
          cplp_pkg::OP_HT: begin
            state_nxt = ST_UPD;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_full) begin
          cmd.put_out = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= cplp_pkg::OP_VD;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

// ===== rtl/cplp_mul.sv =====
// unsigned multiplier: one 16-bit digit of b per step cycle, msb first
module cplp_mul #(
  parameter int AW = 33,
  parameter int ND = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  logic                            step,
  input  logic [AW-1:0]                   a,
  input  logic [AW-1:0]                   b,
  output logic [AW+ND*cplp_pkg::DIG_W-1:0] prod,
  output logic                            last
);

  localparam int DW_D = cplp_pkg::DIG_W;
  localparam int BW   = ND * DW_D;
  localparam int PW   = AW + BW;
  localparam int CW   = $clog2(ND);

  logic [AW-1:0]      a_r;
  logic [BW-1:0]      b_r;
  logic [PW-1:0]      acc_r, acc_nxt;
  logic [CW-1:0]      cnt_r;
  logic [AW+DW_D-1:0] pp;

  assign pp      = a_r * b_r[BW-1 -: DW_D];
  assign acc_nxt = (acc_r << DW_D) + PW'(pp);
  assign prod    = acc_r;
  assign last    = (cnt_r == CW'(ND - 1));

  always_ff @(posedge clk) begin
    if (load) begin
      a_r   <= a;
      b_r   <= BW'(b);
      acc_r <= '0;
    end else if (step) begin
      b_r   <= b_r << DW_D;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

// ===== rtl/cplp_dp.sv =====
// datapath: config registers, plant state, rounding, saturation, result register
module cplp_dp #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cplp_pkg::cmd_t                 cmd,
  output cplp_pkg::sts_t                 sts,
  input  logic                           cfg_we,
  input  logic [cplp_pkg::IDX_W-1:0]     cfg_index,
  input  logic [cplp_pkg::CFG_W-1:0]     cfg_value,
  input  cplp_pkg::in_payload_t          in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cplp_pkg::out_payload_t         out_data
);

  localparam int DW  = DATA_WIDTH;
  localparam int EXW = (DW > cplp_pkg::CFG_W) ? DW : cplp_pkg::CFG_W;
  localparam int MW  = EXW + 1;
  localparam int ND  = (MW + cplp_pkg::DIG_W - 1) / cplp_pkg::DIG_W;
  localparam int PW  = MW + ND * cplp_pkg::DIG_W;
  localparam int RW  = PW + 1;
  localparam int QW  = RW - FRAC_BITS;
  localparam int SW  = DW + 2;

  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [QW-1:0] MAXP_Q = {{(QW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic [QW-1:0] MAXN_Q = MAXP_Q + 1'b1;
  localparam logic [RW-1:0] HALF_N  = RW'(1) << (FRAC_BITS - 1);
  localparam logic [RW-1:0] HALF_HT = RW'(1) << FRAC_BITS;

  logic signed [cplp_pkg::CFG_W-1:0]  tgt_r, gg_r, cg_r;
  logic signed [DW-1:0]               pos_r, vel_r, vd_r, acc_r, dv_r, pv_r, ht_r;
  logic signed [cplp_pkg::STEP_W-1:0] dt_r;
  logic                               err_r, clip_r, neg_r;
  logic                               out_valid_r;
  cplp_pkg::out_payload_t             out_data_r;

  logic signed [MW-1:0] opx, opy;
  logic [MW-1:0]        xmag, ymag;
  logic [PW-1:0]        prod;
  logic                 mul_last;
  logic                 is_ht;
  logic [RW-1:0]        rnd;
  logic [QW-1:0]        q;
  logic                 hclip;
  logic signed [DW-1:0] res;
  logic signed [SW-1:0] sum_p, sum_v;
  logic                 p_clip, v_clip;
  logic signed [DW-1:0] pos_sat, vel_sat;

  function automatic logic signed [cplp_pkg::OUT_W-1:0] to_out(input logic signed [DW-1:0] x);
    logic signed [EXW-1:0] e;
    e = EXW'(x);
    return e[cplp_pkg::OUT_W-1:0];
  endfunction

  // operands of the product in flight
  always_comb begin
    case (cmd.op)
      cplp_pkg::OP_VD: begin
        opx = MW'(gg_r);
        opy = MW'(tgt_r) - MW'(pos_r);
      end
      cplp_pkg::OP_ACC: begin
        opx = MW'(cg_r);
        opy = MW'(vd_r) - MW'(vel_r);
      end
      cplp_pkg::OP_DV: begin
        opx = MW'(acc_r);
        opy = MW'(dt_r);
      end
      cplp_pkg::OP_PV: begin
        opx = MW'(vel_r);
        opy = MW'(dt_r);
      end
      cplp_pkg::OP_HT: begin
        opx = MW'(dv_r);
        opy = MW'(dt_r);
      end
      default: begin
        opx = '0;
        opy = '0;
      end
    endcase
    xmag = opx[MW-1] ? MW'(-opx) : MW'(opx);
    ymag = opy[MW-1] ? MW'(-opy) : MW'(opy);
  end

  cplp_mul #(
    .AW (MW),
    .ND (ND)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cmd.mul_load),
    .step  (cmd.mul_step),
    .a     (xmag),
    .b     (ymag),
    .prod  (prod),
    .last  (mul_last)
  );

  // round half away from zero on the magnitude, then clip
  always_comb begin
    is_ht = (cmd.op == cplp_pkg::OP_HT);
    rnd   = RW'(prod) + (is_ht ? HALF_HT : HALF_N);
    q     = is_ht ? {1'b0, rnd[RW-1:FRAC_BITS+1]} : rnd[RW-1:FRAC_BITS];
    if (neg_r) begin
      hclip = (q > MAXN_Q);
      res   = hclip ? DMIN : $signed(-q[DW-1:0]);
    end else begin
      hclip = (q > MAXP_Q);
      res   = hclip ? DMAX : $signed(q[DW-1:0]);
    end
  end

  // plant integration sums
  always_comb begin
    sum_p   = SW'(pos_r) + SW'(pv_r) + SW'(ht_r);
    sum_v   = SW'(vel_r) + SW'(dv_r);
    p_clip  = (sum_p[SW-1:DW-1] != {3{sum_p[SW-1]}});
    v_clip  = (sum_v[SW-1:DW-1] != {3{sum_v[SW-1]}});
    pos_sat = p_clip ? (sum_p[SW-1] ? DMIN : DMAX) : sum_p[DW-1:0];
    vel_sat = v_clip ? (sum_v[SW-1] ? DMIN : DMAX) : sum_v[DW-1:0];
  end

  // config and plant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= cplp_pkg::TARGET_RESET;
      gg_r  <= cplp_pkg::GAIN_RESET;
      cg_r  <= cplp_pkg::GAIN_RESET;
      pos_r <= '0;
      vel_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cplp_pkg::REG_TARGET_POSITION: tgt_r <= $signed(cfg_value);
          cplp_pkg::REG_GUIDANCE_GAIN:   gg_r  <= $signed(cfg_value);
          cplp_pkg::REG_CONTROL_GAIN:    cg_r  <= $signed(cfg_value);
          default: begin
          end
        endcase
      end
      if (cmd.update) begin
        pos_r <= pos_sat;
        vel_r <= vel_sat;
      end
    end
  end

  // per-request working registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      dt_r   <= in_data.time_step;
      err_r  <= in_data.time_step[cplp_pkg::STEP_W-1];
      clip_r <= 1'b0;
    end else if (cmd.mul_fin) begin
      clip_r <= clip_r | hclip;
    end else if (cmd.update) begin
      clip_r <= clip_r | p_clip | v_clip;
    end
    if (cmd.mul_load) begin
      neg_r <= opx[MW-1] ^ opy[MW-1];
    end
    if (cmd.mul_fin) begin
      case (cmd.op)
        cplp_pkg::OP_VD:  vd_r  <= res;
        cplp_pkg::OP_ACC: acc_r <= res;
        cplp_pkg::OP_DV:  dv_r  <= res;
        cplp_pkg::OP_PV:  pv_r  <= res;
        cplp_pkg::OP_HT:  ht_r  <= res;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.put_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_out) begin
      out_data_r.position_out  <= to_out(pos_r);
      out_data_r.velocity_out  <= to_out(vel_r);
      out_data_r.control_accel <= to_out(acc_r);
      out_data_r.step_error    <= err_r;
      out_data_r.saturated     <= clip_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.mul_last = mul_last;
  assign sts.step_err = err_r;
  assign sts.out_full = out_valid_r && !out_ready;

endmodule

// ===== rtl/cascaded_p_loop_with_kinematic_plant_core.sv =====
// top level of the cascaded position/velocity p controller with kinematic plant
//
//   channel  dir  payload                                           handshake
//   in_s     in   time_step                                         valid/ready
//   out_s    out  position_out velocity_out control_accel flags     valid/ready
//   cfg_s    in   index value (target, guidance gain, control gain) valid/ready
//
// one request at a time; the shared digit multiplier works on ND 16-bit digits,
// ND = ceil((max(DATA_WIDTH,32)+1)/16); normal step: five products, then the update;
// negative step: two products; the next request is taken while the previous result
// still waits in out_s; a stalled result holds the sequencer in its last state only
// when a new one is done; synchronous active-low reset; config is always ready; the
// user must write it only while idle, the block itself does not enforce this
`include "cascaded_p_loop_with_kinematic_plant_core_assert.svh"

module cascaded_p_loop_with_kinematic_plant_core #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  cplp_stream_if.sink   in_s,
  cplp_stream_if.source out_s,
  cplp_stream_if.sink   cfg_s
);

  cplp_pkg::cmd_t cmd;
  cplp_pkg::sts_t sts;
  logic           in_ready;

  // sequencer: vd, accel, a*dt, v*dt, half term, update; a negative step ends at accel
  cplp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: registers, multiplier, rounding and clipping, result register
  cplp_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_s.valid),
    .cfg_index (cfg_s.data.index),
    .cfg_value (cfg_s.data.value),
    .in_data   (in_s.data),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .out_data  (out_s.data)
  );

  assign in_s.ready  = in_ready;
  // config writes are always accepted and registered directly
  assign cfg_s.ready = 1'b1;

  // a taken request keeps the input closed for the next cycle
  `CPLP_ASSERT_NEXT(a_in_closed, in_s.valid && in_s.ready, !in_s.ready)
  // a new result never overwrites one still waiting
  `CPLP_ASSERT_IMPLY(a_no_overwrite, cmd.put_out, !out_s.valid || out_s.ready)
  // a negative step never moves the plant
  `CPLP_ASSERT_IMPLY(a_err_no_update, cmd.update, !sts.step_err)
  // rounding only follows the last multiplier digit
  `CPLP_ASSERT_IMPLY(a_fin_after_last, cmd.mul_fin, $past(cmd.mul_step && sts.mul_last))

endmodule
